>>> src/imu_dr_pkg.sv
// ---------------------------------------------------------------------------
// imu_dr_pkg
// shared types and widths for the imu dead reckoning pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package imu_dr_pkg;

   // serial multiplier operand widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic        [15:0] time_step;
      logic        [14:0] still_threshold;
      logic        [4:0]  still_count_needed;
      logic        [15:0] velocity_decay;
      logic        [15:0] filter_input_scale;
      logic signed [17:0] filter_feedback_older;
      logic signed [17:0] filter_feedback_newer;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] smooth;
      logic signed [31:0] velocity;
      logic signed [31:0] position;
   } axis_result_type;

endpackage

`default_nettype wire

>>> src/imu_dr_mult.sv
// ---------------------------------------------------------------------------
// imu_dr_mult
// bit-serial signed multiplier, one multiplier bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module imu_dr_mult import imu_dr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [MUL_A_W-1:0] a,
   input  wire logic signed [MUL_B_W-1:0] b,
   output logic                           done,
   output logic signed [MUL_P_W-1:0]      p
);

   localparam int CNT_W = $clog2(MUL_B_W);

   logic signed [MUL_A_W-1:0] a_ff;
   logic signed [MUL_A_W:0]   hi_ff;
   logic        [MUL_B_W-1:0] lo_ff;
   logic        [CNT_W-1:0]   cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;

   logic                      last;
   logic signed [MUL_A_W+1:0] a_ext;
   logic signed [MUL_A_W+1:0] addend;
   logic signed [MUL_A_W+1:0] hs_in;

   always_comb begin
      last  = (cnt_ff == CNT_W'(MUL_B_W - 1));
      a_ext = (MUL_A_W+2)'(a_ff);
      // top bit of b carries negative weight
      if (lo_ff[0]) begin
         addend = last ? -a_ext : a_ext;
      end else begin
         addend = '0;
      end
      hs_in = (MUL_A_W+2)'(hi_ff) + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= a;
            hi_ff   <= '0;
            lo_ff   <= b;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            hi_ff  <= hs_in[MUL_A_W+1:1];
            lo_ff  <= {hs_in[0], lo_ff[MUL_B_W-1:1]};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign p    = $signed(MUL_P_W'({hi_ff, lo_ff}));

endmodule

`default_nettype wire

>>> src/imu_dr_div.sv
// ---------------------------------------------------------------------------
// imu_dr_div
// restoring divider by a fixed divisor, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module imu_dr_div #(
   parameter int WIDTH   = 21,
   parameter int DIVISOR = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   output logic                  done,
   output logic [WIDTH-1:0]      quotient
);

   localparam int RW    = $clog2(DIVISOR) + 1;
   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] uq_ff;
   logic [RW-1:0]    rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [RW:0]      trial_in;
   logic             qbit_in;
   logic [RW:0]      diff_in;

   always_comb begin
      trial_in = {rem_ff, uq_ff[WIDTH-1]};
      qbit_in  = (trial_in >= (RW+1)'(DIVISOR));
      diff_in  = trial_in - (RW+1)'(DIVISOR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            uq_ff   <= dividend;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            uq_ff  <= {uq_ff[WIDTH-2:0], qbit_in};
            rem_ff <= qbit_in ? diff_in[RW-1:0] : trial_in[RW-1:0];
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = uq_ff;

endmodule

`default_nettype wire

>>> src/imu_dr_axis.sv
// ---------------------------------------------------------------------------
// imu_dr_axis
// one axis lane: filter, smoothing window, velocity and position integration
// ---------------------------------------------------------------------------
`default_nettype none

module imu_dr_axis import imu_dr_pkg::*; #(
   parameter int HISTORY_DEPTH  = 25,
   parameter int AVERAGE_WINDOW = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               start,
   input  wire logic signed [15:0] sample,
   input  wire logic               ack,
   output logic                    done,
   output axis_result_type         result
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W = CNT_W + 5;
   localparam int SUM_W = 17 + $clog2(AVERAGE_WINDOW + 1);
   localparam logic signed [SUM_W-1:0] HALF_WINDOW = SUM_W'(AVERAGE_WINDOW / 2);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_OLDER, ST_NEWER, ST_FILT, ST_PUSH1, ST_SCAN,
      ST_DIV_GO, ST_DIV, ST_PUSH2, ST_VEL, ST_DECAY_GO, ST_DECAY, ST_POS_GO,
      ST_POS, ST_DONE
   } state_type;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v, input int w);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   state_type                 state_ff;
   logic signed [15:0]        sample_ff;
   logic                      primed_ff;
   logic signed [23:0]        xs_ff [3];
   logic signed [23:0]        ys_ff [3];
   logic signed [42:0]        fb_ff;
   logic signed [15:0]        filt_ff;
   logic signed [15:0]        avg_ff;
   logic signed [15:0]        win_ff [HISTORY_DEPTH];
   logic        [IDX_W-1:0]   idx_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic        [CNT_W-1:0]   cnt_ff;
   logic                      neg_ff;
   logic signed [15:0]        prior_ff;
   logic signed [31:0]        sn_ff;
   logic signed [31:0]        sb_ff;
   logic signed [31:0]        place_ff;
   logic                      mul_start_ff;
   logic signed [MUL_A_W-1:0] mul_a_ff;
   logic signed [MUL_B_W-1:0] mul_b_ff;
   logic                      div_start_ff;
   logic        [SUM_W-1:0]   div_u_ff;

   logic                      mul_done;
   logic signed [MUL_P_W-1:0] prod;
   logic                      div_done;
   logic        [SUM_W-1:0]   div_q;

   logic signed [16:0]        thr;
   logic signed [16:0]        head17;
   logic signed [16:0]        avg17;
   logic                      head_in_bound;
   logic                      avg_in_bound;
   logic signed [23:0]        x_scaled;
   logic signed [63:0]        y_full;
   logic signed [SUM_W-1:0]   n_biased;
   logic signed [SUM_W-1:0]   q_signed;
   logic signed [63:0]        vel_sum;
   logic                      still;

   imu_dr_mult u_mult (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a     (mul_a_ff),
      .b     (mul_b_ff),
      .done  (mul_done),
      .p     (prod)
   );

   imu_dr_div #(
      .WIDTH   (SUM_W),
      .DIVISOR (AVERAGE_WINDOW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_u_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      thr           = $signed({2'b00, cfg.still_threshold});
      head17        = 17'(win_ff[0]);
      avg17         = 17'(avg_ff);
      head_in_bound = (head17 <= thr) && (head17 >= -thr);
      avg_in_bound  = (avg17 <= thr) && (avg17 >= -thr);
      x_scaled      = 24'(clamp(rnd(64'(prod), 10), 24));
      y_full        = 64'(xs_ff[0]) + (64'(xs_ff[1]) <<< 1) + 64'(xs_ff[2])
                    + rnd(64'(fb_ff) + 64'(prod), 16);
      n_biased      = sum_ff + HALF_WINDOW;
      // floor division of a negative value: ~((~n) / d)
      q_signed      = neg_ff ? $signed(~div_q) : $signed(div_q);
      vel_sum       = 64'(sn_ff) + rnd(64'(prod), 9);
      still         = (CMP_W'(cnt_ff) >= CMP_W'(cfg.still_count_needed));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         prior_ff     <= '0;
         sn_ff        <= '0;
         sb_ff        <= '0;
         place_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            xs_ff[i] <= '0;
            ys_ff[i] <= '0;
         end
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  sample_ff    <= sample;
                  mul_a_ff     <= MUL_A_W'(sample);
                  mul_b_ff     <= $signed({2'b00, cfg.filter_input_scale});
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (mul_done) begin
                  if (!primed_ff) begin
                     // first sample loads the whole filter history
                     primed_ff <= 1'b1;
                     for (int i = 0; i < 3; i++) begin
                        xs_ff[i] <= x_scaled;
                        ys_ff[i] <= 24'(64'(sample_ff) <<< 6);
                     end
                     filt_ff  <= sample_ff;
                     state_ff <= ST_PUSH1;
                  end else begin
                     xs_ff[0]     <= xs_ff[1];
                     xs_ff[1]     <= xs_ff[2];
                     xs_ff[2]     <= x_scaled;
                     ys_ff[0]     <= ys_ff[1];
                     ys_ff[1]     <= ys_ff[2];
                     mul_a_ff     <= MUL_A_W'(ys_ff[1]);
                     mul_b_ff     <= cfg.filter_feedback_older;
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_OLDER;
                  end
               end
            end
            ST_OLDER: begin
               if (mul_done) begin
                  fb_ff        <= 43'(prod);
                  mul_a_ff     <= MUL_A_W'(ys_ff[1]);
                  mul_b_ff     <= cfg.filter_feedback_newer;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_NEWER;
               end
            end
            ST_NEWER: begin
               if (mul_done) begin
                  ys_ff[2] <= 24'(clamp(y_full, 24));
                  state_ff <= ST_FILT;
               end
            end
            ST_FILT: begin
               filt_ff  <= 16'(clamp(rnd(64'(ys_ff[2]), 6), 16));
               state_ff <= ST_PUSH1;
            end
            ST_PUSH1: begin
               for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                  win_ff[i] <= win_ff[i-1];
               end
               win_ff[0] <= filt_ff;
               idx_ff    <= '0;
               sum_ff    <= '0;
               cnt_ff    <= '0;
               state_ff  <= ST_SCAN;
            end
            ST_SCAN: begin
               // rotate once around; the oldest entry drops at the second push
               for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                  win_ff[i] <= win_ff[i+1];
               end
               win_ff[HISTORY_DEPTH-1] <= win_ff[0];
               if (int'(idx_ff) < AVERAGE_WINDOW) begin
                  sum_ff <= sum_ff + SUM_W'(win_ff[0]);
               end
               if ((idx_ff != IDX_W'(HISTORY_DEPTH - 1)) && head_in_bound) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
               idx_ff <= idx_ff + IDX_W'(1);
               if (idx_ff == IDX_W'(HISTORY_DEPTH - 1)) begin
                  state_ff <= ST_DIV_GO;
               end
            end
            ST_DIV_GO: begin
               neg_ff       <= n_biased[SUM_W-1];
               div_u_ff     <= n_biased[SUM_W-1] ? ~n_biased : n_biased;
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  avg_ff   <= 16'(clamp(64'(q_signed), 16));
                  state_ff <= ST_PUSH2;
               end
            end
            ST_PUSH2: begin
               for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                  win_ff[i] <= win_ff[i-1];
               end
               win_ff[0] <= avg_ff;
               if (avg_in_bound) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
               mul_a_ff     <= MUL_A_W'(prior_ff) + MUL_A_W'(avg_ff);
               mul_b_ff     <= $signed({2'b00, cfg.time_step});
               mul_start_ff <= 1'b1;
               state_ff     <= ST_VEL;
            end
            ST_VEL: begin
               if (mul_done) begin
                  prior_ff <= avg_ff;
                  sb_ff    <= sn_ff;
                  sn_ff    <= 32'(clamp(vel_sum, 32));
                  state_ff <= still ? ST_DECAY_GO : ST_POS_GO;
               end
            end
            ST_DECAY_GO: begin
               mul_a_ff     <= MUL_A_W'(sn_ff);
               mul_b_ff     <= $signed({2'b00, cfg.velocity_decay});
               mul_start_ff <= 1'b1;
               state_ff     <= ST_DECAY;
            end
            ST_DECAY: begin
               if (mul_done) begin
                  sb_ff    <= sn_ff;
                  sn_ff    <= 32'(clamp(rnd(64'(prod), 16), 32));
                  state_ff <= ST_POS_GO;
               end
            end
            ST_POS_GO: begin
               mul_a_ff     <= MUL_A_W'(sb_ff) + MUL_A_W'(sn_ff);
               mul_b_ff     <= $signed({2'b00, cfg.time_step});
               mul_start_ff <= 1'b1;
               state_ff     <= ST_POS;
            end
            ST_POS: begin
               if (mul_done) begin
                  place_ff <= 32'(clamp(64'(place_ff) + rnd(64'(prod), 17), 32));
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (ack) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done            = (state_ff == ST_DONE);
   assign result.smooth   = prior_ff;
   assign result.velocity = sn_ff;
   assign result.position = place_ff;

endmodule

`default_nettype wire

>>> src/imu_dead_reckoning_pipeline_unit.sv
// per lane, each request takes multiplier passes for input scale, older and newer feedback,
// velocity, decay and position, plus the window scan and the serial divide; the decay pass
// runs only when the still count is reached, and the first request skips both feedback passes
// a new request is accepted only once the previous result is loaded into the response
// register, which waits for rsp_tready; the three axes run in parallel lanes.
// reset: synchronous, clears filters, window, velocity and position, loads config defaults.
// ---------------------------------------------------------------------------
// imu_dead_reckoning_pipeline_unit
// three-axis accel filter, smoothing and integration into velocity and position
// ---------------------------------------------------------------------------
`default_nettype none

module imu_dead_reckoning_pipeline_unit import imu_dr_pkg::*; #(
   parameter int HISTORY_DEPTH  = 25,
   parameter int AVERAGE_WINDOW = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // accel_x, accel_y, accel_z
   input  wire logic [47:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // smooth_accel_x/y/z, velocity_x/y/z, position_x/y/z
   output logic [239:0]      rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam logic [2:0] REG_TIME_STEP     = 3'd0;
   localparam logic [2:0] REG_STILL_THRESH  = 3'd1;
   localparam logic [2:0] REG_STILL_COUNT   = 3'd2;
   localparam logic [2:0] REG_VEL_DECAY     = 3'd3;
   localparam logic [2:0] REG_INPUT_SCALE   = 3'd4;
   localparam logic [2:0] REG_FB_OLDER      = 3'd5;
   localparam logic [2:0] REG_FB_NEWER      = 3'd6;

   cfg_type         cfg_ff;
   logic            busy_ff;
   logic            rsp_tvalid_ff;
   logic [239:0]    rsp_tdata_ff;

   logic            csr_we;
   logic [2:0]      csr_index;
   logic            accept;
   logic            load;
   logic [2:0]      lane_done;
   axis_result_type lane_res [3];

   assign csr_index = csr_paddr[4:2];
   assign csr_we    = csr_psel && csr_penable && csr_pwrite;
   assign accept    = req_tvalid && !busy_ff;
   assign load      = busy_ff && (&lane_done) && (!rsp_tvalid_ff || rsp_tready);

   for (genvar g = 0; g < 3; g++) begin : g_lane
      imu_dr_axis #(
         .HISTORY_DEPTH  (HISTORY_DEPTH),
         .AVERAGE_WINDOW (AVERAGE_WINDOW)
      ) u_axis (
         .clock  (clock),
         .reset  (reset),
         .cfg    (cfg_ff),
         .start  (accept),
         .sample ($signed(req_tdata[16*g +: 16])),
         .ack    (load),
         .done   (lane_done[g]),
         .result (lane_res[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step             <= 16'd655;
         cfg_ff.still_threshold       <= 15'd256;
         cfg_ff.still_count_needed    <= 5'd25;
         cfg_ff.velocity_decay        <= 16'd9830;
         cfg_ff.filter_input_scale    <= 16'd4421;
         cfg_ff.filter_feedback_older <= -18'sd27053;
         cfg_ff.filter_feedback_newer <= 18'sd74907;
         busy_ff                      <= 1'b0;
         rsp_tvalid_ff                <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_TIME_STEP:    cfg_ff.time_step             <= csr_pwdata[15:0];
               REG_STILL_THRESH: cfg_ff.still_threshold       <= csr_pwdata[14:0];
               REG_STILL_COUNT:  cfg_ff.still_count_needed    <= csr_pwdata[4:0];
               REG_VEL_DECAY:    cfg_ff.velocity_decay        <= csr_pwdata[15:0];
               REG_INPUT_SCALE:  cfg_ff.filter_input_scale    <= csr_pwdata[15:0];
               REG_FB_OLDER:     cfg_ff.filter_feedback_older <= $signed(csr_pwdata[17:0]);
               REG_FB_NEWER:     cfg_ff.filter_feedback_newer <= $signed(csr_pwdata[17:0]);
               default: begin
               end
            endcase
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (load) begin
            busy_ff <= 1'b0;
         end
         if (load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_tdata_ff <= {lane_res[2].position, lane_res[1].position, lane_res[0].position,
                          lane_res[2].velocity, lane_res[1].velocity, lane_res[0].velocity,
                          lane_res[2].smooth,   lane_res[1].smooth,   lane_res[0].smooth};
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TIME_STEP:    csr_prdata = 32'(cfg_ff.time_step);
         REG_STILL_THRESH: csr_prdata = 32'(cfg_ff.still_threshold);
         REG_STILL_COUNT:  csr_prdata = 32'(cfg_ff.still_count_needed);
         REG_VEL_DECAY:    csr_prdata = 32'(cfg_ff.velocity_decay);
         REG_INPUT_SCALE:  csr_prdata = 32'(cfg_ff.filter_input_scale);
         REG_FB_OLDER:     csr_prdata = 32'(cfg_ff.filter_feedback_older);
         REG_FB_NEWER:     csr_prdata = 32'(cfg_ff.filter_feedback_newer);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

>>> src/imu_dr_checker.sv
// ---------------------------------------------------------------------------
// imu_dr_checker
// port-level checks for the imu dead reckoning pipeline
// ---------------------------------------------------------------------------
`default_nettype none

module imu_dr_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [239:0] rsp_tdata,
   input wire logic         csr_psel,
   input wire logic         csr_penable,
   input wire logic         csr_pwrite,
   input wire logic [4:0]   csr_paddr,
   input wire logic [31:0]  csr_pwdata,
   input wire logic [31:0]  csr_prdata,
   input wire logic         csr_pready
);

   // one request in flight at a time
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a request was in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("stalled response changed");

   // time step readback right after a write
   a_time_step_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 5'd0)
      |=> (!csr_psel || csr_pwrite || csr_paddr != 5'd0 ||
           csr_prdata[15:0] == $past(csr_pwdata[15:0])))
      else $error("time step register readback mismatch");

endmodule

bind imu_dead_reckoning_pipeline_unit imu_dr_checker u_imu_dr_checker (.*);

`default_nettype wire
